/* sv/topological_sort_kahn_unit_defines.svh */
// Assertion macros shared by the sort unit.
`ifndef TOPOLOGICAL_SORT_KAHN_UNIT_DEFINES_SVH
`define TOPOLOGICAL_SORT_KAHN_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TSK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sort unit check failed");

// Next-cycle implication, checked out of reset.
`define TSK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sort unit check failed");

`endif

/* sv/tsk_pkg.sv */
package tsk_pkg;

    typedef enum logic [1:0] {
        OP_ADD_NODE = 2'd0,
        OP_ADD_EDGE = 2'd1,
        OP_RUN      = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] node_label;
        logic signed [15:0] target_label;
    } t_req;

    typedef struct packed {
        logic signed [15:0] out_label;
        logic               is_node;
        logic               last;
        logic [5:0]         emitted_count;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_EDGE_RD,
        S_EDGE_WR,
        S_SCAN,
        S_PUSH,
        S_POP,
        S_POP_WAIT,
        S_EMIT,
        S_DEC,
        S_TERM
    } t_state;

endpackage

/* sv/tsk_stream_if.sv */
interface tsk_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/topological_sort_kahn_unit.sv */
// Channel   Dir  Payload                                   Handshake
// i_req     in   op, node_label, target_label (tsk_pkg)    valid/ready
// o_rsp     out  out_label, is_node, last, emitted_count   valid/ready
//
// Add node: accepted in the idle state. Add edge: a read and a compare state per stored node for
// the label search, then a state to test the hits and one to update the row (only the test when
// a label is unknown). Run: a scan, a push per initially ready node, then pop, read, emit and
// decrement per emitted node plus a push per successor that becomes ready, then the terminator.
// Reset (synchronous, active low) empties the graph; label and queue memories are
// not cleared. A stalled o_rsp holds the sequencer in its emit or terminator state.
`include "topological_sort_kahn_unit_defines.svh"

module topological_sort_kahn_unit #(
    parameter int MAX_NODES  = 32,
    parameter int LABEL_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tsk_stream_if.sink   i_req,
    tsk_stream_if.source o_rsp
);
    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_NODES);

    // Sequencer and graph control state.
    tsk_pkg::t_state         r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [LABEL_BITS-1:0]   r_src, n_src;
    logic [LABEL_BITS-1:0]   r_dst, n_dst;
    logic [CW-1:0]           r_idx, n_idx;
    logic                    r_hit_a, n_hit_a;
    logic                    r_hit_b, n_hit_b;
    logic [IW-1:0]           r_a, n_a;
    logic [IW-1:0]           r_b, n_b;
    logic [MAX_NODES-1:0]    r_rowv, n_rowv;
    logic [CW-1:0]           r_indeg [MAX_NODES];
    logic [CW-1:0]           n_indeg [MAX_NODES];
    logic [MAX_NODES-1:0]    r_mask, n_mask;
    logic [CW-1:0]           r_head, n_head;
    logic [CW-1:0]           r_tail, n_tail;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [IW-1:0]           r_node, n_node;
    logic                    r_ov, n_ov;
    tsk_pkg::t_rsp           r_rsp, n_rsp;

    // Memory ports.
    logic                    lab_we, lab_re;
    logic [IW-1:0]           lab_wa, lab_ra;
    logic [LABEL_BITS-1:0]   lab_q;
    logic                    adj_we, adj_re;
    logic [IW-1:0]           adj_wa, adj_ra;
    logic [MAX_NODES-1:0]    adj_wd, adj_q;
    logic                    q_we, q_re;
    logic [IW-1:0]           q_wa, q_ra, q_wd, q_q;

    logic signed [31:0]      w_src_ext, w_dst_ext, w_lab_ext;
    logic signed [LABEL_BITS-1:0] w_lab;
    logic [MAX_NODES-1:0]    w_row, w_row_new;
    logic [IW-1:0]           w_sel;
    logic                    w_free;
    logic [CW-1:0]           w_d;

    // Labels are widened from 16 bits, then cut to LABEL_BITS.
    assign w_src_ext = 32'(i_req.data.node_label);
    assign w_dst_ext = 32'(i_req.data.target_label);
    assign w_lab     = lab_q;
    assign w_lab_ext = 32'(w_lab);

    assign w_free      = !r_ov || o_rsp.ready;
    assign i_req.ready = (r_state == tsk_pkg::S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_rsp;

    // The new label is written straight from the accepted request.
    tsk_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_NODES)) u_label_ram (
        .i_clk(i_clk), .i_wr_en(lab_we), .i_wr_addr(lab_wa),
        .i_wr_data(w_src_ext[LABEL_BITS-1:0]),
        .i_rd_en(lab_re), .i_rd_addr(lab_ra), .o_rd_data(lab_q)
    );

    tsk_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj_ram (
        .i_clk(i_clk), .i_wr_en(adj_we), .i_wr_addr(adj_wa), .i_wr_data(adj_wd),
        .i_rd_en(adj_re), .i_rd_addr(adj_ra), .o_rd_data(adj_q)
    );

    tsk_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_queue_ram (
        .i_clk(i_clk), .i_wr_en(q_we), .i_wr_addr(q_wa), .i_wr_data(q_wd),
        .i_rd_en(q_re), .i_rd_addr(q_ra), .o_rd_data(q_q)
    );

    // Lowest pending index in the ready mask; enqueues go in index order.
    always_comb begin
        w_sel = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_sel = IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsk_pkg::S_IDLE;
            r_count <= '0;
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
            r_rowv  <= '0;
            r_indeg <= '{default: '0};
            r_mask  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hit_a <= n_hit_a;
            r_hit_b <= n_hit_b;
            r_rowv  <= n_rowv;
            r_indeg <= n_indeg;
            r_mask  <= n_mask;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_ov    <= n_ov;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_a    <= n_a;
        r_b    <= n_b;
        r_node <= n_node;
        r_rsp  <= n_rsp;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_src   = r_src;
        n_dst   = r_dst;
        n_idx   = r_idx;
        n_hit_a = r_hit_a;
        n_hit_b = r_hit_b;
        n_a     = r_a;
        n_b     = r_b;
        n_rowv  = r_rowv;
        n_indeg = r_indeg;
        n_mask  = r_mask;
        n_head  = r_head;
        n_tail  = r_tail;
        n_cnt   = r_cnt;
        n_node  = r_node;
        n_ov    = r_ov && !o_rsp.ready;
        n_rsp   = r_rsp;

        lab_we = 1'b0;
        lab_wa = r_count[IW-1:0];
        lab_re = 1'b0;
        lab_ra = r_idx[IW-1:0];
        adj_we = 1'b0;
        adj_wa = r_a;
        adj_re = 1'b0;
        adj_ra = r_a;
        q_we   = 1'b0;
        q_wa   = r_tail[IW-1:0];
        q_wd   = w_sel;
        q_re   = 1'b0;
        q_ra   = r_head[IW-1:0];

        // Rows never written since the last clear read as empty.
        w_row = r_rowv[r_a] ? adj_q : '0;
        if (r_state == tsk_pkg::S_DEC) begin
            w_row = r_rowv[r_node] ? adj_q : '0;
        end
        w_row_new = w_row;
        w_row_new[r_b] = 1'b1;
        adj_wd = w_row_new;
        w_d = '0;

        unique case (r_state)
            tsk_pkg::S_IDLE: begin
                n_src = w_src_ext[LABEL_BITS-1:0];
                n_dst = w_dst_ext[LABEL_BITS-1:0];
                if (i_req.valid) begin
                    case (i_req.data.op)
                        tsk_pkg::OP_ADD_NODE: begin
                            // Drop the request once the store is full.
                            if (r_count < MaxCnt) begin
                                lab_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        tsk_pkg::OP_ADD_EDGE: begin
                            n_idx   = '0;
                            n_hit_a = 1'b0;
                            n_hit_b = 1'b0;
                            if (r_count != '0) begin
                                n_state = tsk_pkg::S_FIND_RD;
                            end
                        end
                        tsk_pkg::OP_RUN: begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_cnt   = '0;
                            n_state = tsk_pkg::S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tsk_pkg::S_FIND_RD: begin
                lab_re  = 1'b1;
                n_state = tsk_pkg::S_FIND_CMP;
            end
            tsk_pkg::S_FIND_CMP: begin
                // Ascending scan: the last match wins.
                if (lab_q == r_src) begin
                    n_hit_a = 1'b1;
                    n_a     = r_idx[IW-1:0];
                end
                if (lab_q == r_dst) begin
                    n_hit_b = 1'b1;
                    n_b     = r_idx[IW-1:0];
                end
                n_idx = r_idx + CW'(1);
                if (n_idx == r_count) begin
                    n_state = tsk_pkg::S_EDGE_RD;
                end else begin
                    n_state = tsk_pkg::S_FIND_RD;
                end
            end
            tsk_pkg::S_EDGE_RD: begin
                if (r_hit_a && r_hit_b) begin
                    adj_re  = 1'b1;
                    n_state = tsk_pkg::S_EDGE_WR;
                end else begin
                    n_state = tsk_pkg::S_IDLE;
                end
            end
            tsk_pkg::S_EDGE_WR: begin
                // Duplicate edges leave the in-degree alone.
                if (!w_row[r_b]) begin
                    adj_we        = 1'b1;
                    n_rowv[r_a]   = 1'b1;
                    n_indeg[r_b]  = r_indeg[r_b] + CW'(1);
                end
                n_state = tsk_pkg::S_IDLE;
            end
            tsk_pkg::S_SCAN: begin
                for (int i = 0; i < MAX_NODES; i++) begin
                    n_mask[i] = (CW'(i) < r_count) && (r_indeg[i] == '0);
                end
                n_state = tsk_pkg::S_PUSH;
            end
            tsk_pkg::S_PUSH: begin
                if (r_mask == '0) begin
                    n_state = tsk_pkg::S_POP;
                end else if (r_tail < MaxCnt) begin
                    q_we          = 1'b1;
                    n_tail        = r_tail + CW'(1);
                    n_mask[w_sel] = 1'b0;
                end else begin
                    n_mask = '0;
                end
            end
            tsk_pkg::S_POP: begin
                if (r_head < r_tail) begin
                    q_re    = 1'b1;
                    n_head  = r_head + CW'(1);
                    n_state = tsk_pkg::S_POP_WAIT;
                end else begin
                    n_state = tsk_pkg::S_TERM;
                end
            end
            tsk_pkg::S_POP_WAIT: begin
                n_node  = q_q;
                lab_re  = 1'b1;
                lab_ra  = q_q;
                adj_re  = 1'b1;
                adj_ra  = q_q;
                n_state = tsk_pkg::S_EMIT;
            end
            tsk_pkg::S_EMIT: begin
                // Hold here while the output register is occupied.
                if (w_free) begin
                    n_cnt = r_cnt + CW'(1);
                    n_ov  = 1'b1;
                    n_rsp.out_label     = w_lab_ext[15:0];
                    n_rsp.is_node       = 1'b1;
                    n_rsp.last          = 1'b0;
                    n_rsp.emitted_count = 6'(n_cnt);
                    n_state = tsk_pkg::S_DEC;
                end
            end
            tsk_pkg::S_DEC: begin
                // Decrement all successors at once; collect those that reach zero.
                n_mask = '0;
                for (int i = 0; i < MAX_NODES; i++) begin
                    if (w_row[i] && (CW'(i) < r_count)) begin
                        w_d = (r_indeg[i] != '0) ? r_indeg[i] - CW'(1) : '0;
                        n_indeg[i] = w_d;
                        n_mask[i]  = (w_d == '0);
                    end
                end
                n_state = tsk_pkg::S_PUSH;
            end
            tsk_pkg::S_TERM: begin
                if (w_free) begin
                    n_ov = 1'b1;
                    n_rsp.out_label     = '0;
                    n_rsp.is_node       = 1'b0;
                    n_rsp.last          = 1'b1;
                    n_rsp.emitted_count = 6'(r_cnt);
                    // Clear the graph for the next load.
                    n_count = '0;
                    n_rowv  = '0;
                    n_indeg = '{default: '0};
                    n_head  = '0;
                    n_tail  = '0;
                    n_cnt   = '0;
                    n_state = tsk_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tsk_pkg::S_IDLE;
            end
        endcase
    end

    `TSK_ASSERT_NOW(a_head_le_tail, 1'b1, (r_head <= r_tail) && (r_tail <= MaxCnt))
    `TSK_ASSERT_NOW(a_cnt_le_nodes, r_state != tsk_pkg::S_IDLE, r_cnt <= r_count)
    `TSK_ASSERT_NEXT(a_term_clears, (r_state == tsk_pkg::S_TERM) && w_free,
                     (r_count == '0) && r_ov && r_rsp.last && (r_rowv == '0))
    `TSK_ASSERT_NEXT(a_emit_loads, (r_state == tsk_pkg::S_EMIT) && w_free,
                     r_ov && r_rsp.is_node && (r_state == tsk_pkg::S_DEC))
endmodule

/* sv/tsk_ram.sv */
module tsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
